@@ rtl/core/qrm_pkg.sv @@
// qrm_pkg: payload and pipeline stage types for the quaternion to rotation matrix block
// shared by every file under rtl/core, depends on nothing else
package qrm_pkg;

  localparam int unsigned QuatW   = 16;
  localparam int unsigned ScaleW  = 16;
  localparam int unsigned TransW  = 32;
  // component times scale, signed with 27 fraction bits
  localparam int unsigned ScaledW = QuatW + ScaleW + 1;
  // component times scaled component, 42 fraction bits
  localparam int unsigned ProdW   = 48;
  // sums and one-minus terms before rounding
  localparam int unsigned EntryW  = 50;
  localparam int unsigned RotW    = 16;
  localparam int unsigned NumStages = 4;

  typedef struct packed {
    logic signed [QuatW-1:0]  quat_x;
    logic signed [QuatW-1:0]  quat_y;
    logic signed [QuatW-1:0]  quat_z;
    logic signed [QuatW-1:0]  quat_w;
    logic        [ScaleW-1:0] norm_scale;
    logic signed [TransW-1:0] trans_x;
    logic signed [TransW-1:0] trans_y;
    logic signed [TransW-1:0] trans_z;
  } quat_in_t;

  typedef struct packed {
    logic signed [RotW-1:0]   rot_00;
    logic signed [RotW-1:0]   rot_01;
    logic signed [RotW-1:0]   rot_02;
    logic signed [RotW-1:0]   rot_10;
    logic signed [RotW-1:0]   rot_11;
    logic signed [RotW-1:0]   rot_12;
    logic signed [RotW-1:0]   rot_20;
    logic signed [RotW-1:0]   rot_21;
    logic signed [RotW-1:0]   rot_22;
    logic signed [TransW-1:0] out_trans_x;
    logic signed [TransW-1:0] out_trans_y;
    logic signed [TransW-1:0] out_trans_z;
  } rot_out_t;

  typedef struct packed {
    logic signed [TransW-1:0] x;
    logic signed [TransW-1:0] y;
    logic signed [TransW-1:0] z;
  } trans_t;

  typedef struct packed {
    logic signed [QuatW-1:0]   qx;
    logic signed [QuatW-1:0]   qy;
    logic signed [QuatW-1:0]   qz;
    logic signed [QuatW-1:0]   qw;
    logic signed [ScaledW-1:0] xs;
    logic signed [ScaledW-1:0] ys;
    logic signed [ScaledW-1:0] zs;
    trans_t                    trans;
  } scaled_t;

  typedef struct packed {
    logic signed [ProdW-1:0] xx;
    logic signed [ProdW-1:0] yy;
    logic signed [ProdW-1:0] zz;
    logic signed [ProdW-1:0] xy;
    logic signed [ProdW-1:0] xz;
    logic signed [ProdW-1:0] yz;
    logic signed [ProdW-1:0] wx;
    logic signed [ProdW-1:0] wy;
    logic signed [ProdW-1:0] wz;
    trans_t                  trans;
  } cross_t;

endpackage

@@ rtl/core/quaternion_to_rotation_matrix.sv @@
// Quaternion to 3x3 rotation matrix, four register stages: scale products, cross
// products, matrix sums, then rounding and saturation to signed q2.14. One transfer
// is taken per cycle unless the output stalls, and results leave in input order.
// Each stage holds its own valid bit and loads whenever it is empty or its contents
// move on, so a stalled output fills the stages behind it before input is refused.
// Translation words pass through untouched alongside the matrix.
// depends on qrm_pkg, qrm_scale, qrm_cross, qrm_entry
module quaternion_to_rotation_matrix (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  qrm_pkg::quat_in_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output qrm_pkg::rot_out_t  out_data_o
);

  localparam int unsigned Last = qrm_pkg::NumStages - 1;

  logic [qrm_pkg::NumStages-1:0] valid_q, valid_d;
  logic [qrm_pkg::NumStages-1:0] adv;
  qrm_pkg::scaled_t scaled;
  qrm_pkg::cross_t  products;

  // a stage may load when it is empty or its item moves on this cycle
  always_comb begin
    adv[Last] = !valid_q[Last] || out_ready_i;
    for (int k = Last - 1; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
  end

  always_comb begin
    valid_d = valid_q;
    for (int k = 0; k < qrm_pkg::NumStages; k++) begin
      if (adv[k]) begin
        valid_d[k] = (k == 0) ? in_valid_i : valid_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  qrm_scale u_scale (
    .clk_i  (clk_i),
    .load_i (adv[0]),
    .in_i   (in_data_i),
    .out_o  (scaled)
  );

  qrm_cross u_cross (
    .clk_i  (clk_i),
    .load_i (adv[1]),
    .in_i   (scaled),
    .out_o  (products)
  );

  qrm_entry u_entry (
    .clk_i      (clk_i),
    .load_sum_i (adv[2]),
    .load_rnd_i (adv[3]),
    .in_i       (products),
    .out_o      (out_data_o)
  );

  assign in_ready_o  = adv[0];
  assign out_valid_o = valid_q[Last];

  // input is refused only with every stage full
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&valid_q))
    else $error("input refused with an empty stage");

  // an input transfer always lands in the first stage
  a_first_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> valid_q[0])
    else $error("accepted item not held in first stage");

  // an item in the third stage moves into the output stage or stays put
  a_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[2] |=> (valid_q[2] || valid_q[3]))
    else $error("item lost between sum and output stage");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

endmodule

@@ rtl/core/qrm_scale.sv @@
// qrm_scale: first pipeline stage, scales x, y and z by the norm scale
// depends on qrm_pkg
module qrm_scale (
  input  logic               clk_i,
  input  logic               load_i,
  input  qrm_pkg::quat_in_t  in_i,
  output qrm_pkg::scaled_t   out_o
);

  qrm_pkg::scaled_t stage_d, stage_q;
  logic signed [qrm_pkg::ScaledW-1:0] scale_ext;

  always_comb begin
    // scale is unsigned, so a zero bit on top keeps it positive
    scale_ext = qrm_pkg::ScaledW'($signed({1'b0, in_i.norm_scale}));
    stage_d.qx = in_i.quat_x;
    stage_d.qy = in_i.quat_y;
    stage_d.qz = in_i.quat_z;
    stage_d.qw = in_i.quat_w;
    stage_d.xs = qrm_pkg::ScaledW'(in_i.quat_x) * scale_ext;
    stage_d.ys = qrm_pkg::ScaledW'(in_i.quat_y) * scale_ext;
    stage_d.zs = qrm_pkg::ScaledW'(in_i.quat_z) * scale_ext;
    stage_d.trans.x = in_i.trans_x;
    stage_d.trans.y = in_i.trans_y;
    stage_d.trans.z = in_i.trans_z;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      stage_q <= stage_d;
    end
  end

  assign out_o = stage_q;

endmodule

@@ rtl/core/qrm_cross.sv @@
// qrm_cross: second pipeline stage, the nine component by scaled component products
// depends on qrm_pkg
module qrm_cross (
  input  logic              clk_i,
  input  logic              load_i,
  input  qrm_pkg::scaled_t  in_i,
  output qrm_pkg::cross_t   out_o
);

  qrm_pkg::cross_t stage_d, stage_q;

  always_comb begin
    stage_d.xx = qrm_pkg::ProdW'(in_i.qx) * qrm_pkg::ProdW'(in_i.xs);
    stage_d.yy = qrm_pkg::ProdW'(in_i.qy) * qrm_pkg::ProdW'(in_i.ys);
    stage_d.zz = qrm_pkg::ProdW'(in_i.qz) * qrm_pkg::ProdW'(in_i.zs);
    stage_d.xy = qrm_pkg::ProdW'(in_i.qy) * qrm_pkg::ProdW'(in_i.xs);
    stage_d.xz = qrm_pkg::ProdW'(in_i.qz) * qrm_pkg::ProdW'(in_i.xs);
    stage_d.yz = qrm_pkg::ProdW'(in_i.qz) * qrm_pkg::ProdW'(in_i.ys);
    stage_d.wx = qrm_pkg::ProdW'(in_i.qw) * qrm_pkg::ProdW'(in_i.xs);
    stage_d.wy = qrm_pkg::ProdW'(in_i.qw) * qrm_pkg::ProdW'(in_i.ys);
    stage_d.wz = qrm_pkg::ProdW'(in_i.qw) * qrm_pkg::ProdW'(in_i.zs);
    stage_d.trans = in_i.trans;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      stage_q <= stage_d;
    end
  end

  assign out_o = stage_q;

endmodule

@@ rtl/core/qrm_entry.sv @@
// qrm_entry: third and fourth pipeline stages, matrix sums then rounding and saturation
// depends on qrm_pkg
module qrm_entry (
  input  logic              clk_i,
  input  logic              load_sum_i,
  input  logic              load_rnd_i,
  input  qrm_pkg::cross_t   in_i,
  output qrm_pkg::rot_out_t out_o
);

  localparam int unsigned NumEntries = 9;
  localparam int unsigned FracDrop   = 28;
  localparam int unsigned ShiftW     = qrm_pkg::EntryW - FracDrop;
  localparam logic signed [qrm_pkg::EntryW-1:0] OneQ42    = 50'sd4398046511104;
  localparam logic signed [qrm_pkg::EntryW-1:0] RoundHalf = 50'sd134217728;
  localparam logic signed [ShiftW-1:0] RotMax = 22'sd32767;
  localparam logic signed [ShiftW-1:0] RotMin = -22'sd32768;

  typedef logic signed [qrm_pkg::EntryW-1:0] entry_t;

  entry_t           sum_d [NumEntries];
  entry_t           sum_q [NumEntries];
  qrm_pkg::trans_t  trans_q;
  qrm_pkg::rot_out_t out_d, out_q;
  logic signed [qrm_pkg::RotW-1:0] rot [NumEntries];

  function automatic entry_t ext(input logic signed [qrm_pkg::ProdW-1:0] v);
    return qrm_pkg::EntryW'(v);
  endfunction

  // round to nearest, ties upwards, then clamp to the q2.14 range
  function automatic logic signed [qrm_pkg::RotW-1:0] to_q14(input entry_t v);
    entry_t                 biased;
    logic signed [ShiftW-1:0] shifted;
    logic signed [qrm_pkg::RotW-1:0] res;
    biased  = v + RoundHalf;
    shifted = ShiftW'(biased >>> FracDrop);
    if (shifted > RotMax) begin
      res = qrm_pkg::RotW'(RotMax);
    end else if (shifted < RotMin) begin
      res = qrm_pkg::RotW'(RotMin);
    end else begin
      res = qrm_pkg::RotW'(shifted);
    end
    return res;
  endfunction

  always_comb begin
    sum_d[0] = OneQ42 - (ext(in_i.yy) + ext(in_i.zz));
    sum_d[1] = ext(in_i.xy) + ext(in_i.wz);
    sum_d[2] = ext(in_i.xz) - ext(in_i.wy);
    sum_d[3] = ext(in_i.xy) - ext(in_i.wz);
    sum_d[4] = OneQ42 - (ext(in_i.xx) + ext(in_i.zz));
    sum_d[5] = ext(in_i.yz) + ext(in_i.wx);
    sum_d[6] = ext(in_i.xz) + ext(in_i.wy);
    sum_d[7] = ext(in_i.yz) - ext(in_i.wx);
    sum_d[8] = OneQ42 - (ext(in_i.xx) + ext(in_i.yy));
  end

  always_ff @(posedge clk_i) begin
    if (load_sum_i) begin
      sum_q   <= sum_d;
      trans_q <= in_i.trans;
    end
  end

  always_comb begin
    for (int i = 0; i < NumEntries; i++) begin
      rot[i] = to_q14(sum_q[i]);
    end
    out_d.rot_00 = rot[0];
    out_d.rot_01 = rot[1];
    out_d.rot_02 = rot[2];
    out_d.rot_10 = rot[3];
    out_d.rot_11 = rot[4];
    out_d.rot_12 = rot[5];
    out_d.rot_20 = rot[6];
    out_d.rot_21 = rot[7];
    out_d.rot_22 = rot[8];
    out_d.out_trans_x = trans_q.x;
    out_d.out_trans_y = trans_q.y;
    out_d.out_trans_z = trans_q.z;
  end

  always_ff @(posedge clk_i) begin
    if (load_rnd_i) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule
